>>> sv/rtd_resistance_to_temperature_macros.svh
// assertion macros for the rtd resistance-to-temperature checker
// depends on nothing; included by the checker file only
`ifndef RTD_RESISTANCE_TO_TEMPERATURE_MACROS_SVH
`define RTD_RESISTANCE_TO_TEMPERATURE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtd check failed");

// next-cycle implication, disabled while reset is low
`define RTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtd check failed");

`endif

>>> sv/rtd_pkg.sv
// shared constants, curve coefficients and controller/datapath structs
// depends on nothing; used by every rtd module
`default_nettype none

package rtd_pkg;

  // fixed-point layout
  localparam int FRAC_W    = 16;
  localparam int CK        = 48;
  localparam int RES_W     = 17;
  localparam int TEMP_W    = 20;
  localparam int ITER_W    = 6;
  localparam int TOL_W     = 16;
  localparam int T_W       = 28;
  localparam int ACC_W     = 62;
  localparam int ACC_SPLIT = 30;
  localparam int RT_W      = ACC_W - (CK - FRAC_W);
  localparam int DEN_W     = 30;
  localparam int NUM_W     = 47;
  localparam int QUO_W     = NUM_W + 1;
  localparam int KIDX_W    = 3;

  // resistance thresholds in 1/256 ohm
  localparam logic [RES_W-1:0] R_LOW  = 17'd4742;
  localparam logic [RES_W-1:0] R_MID  = 17'd25600;
  localparam logic [RES_W-1:0] R_HIGH = 17'd99963;

  // linear estimate t0 = (r - R_MID) * LIN_MUL / LIN_DIV, by reciprocal multiply
  // the reciprocal is rounded up; 2^LIN_SH exceeds max |r - R_MID| * LIN_DIV
  localparam longint LIN_MUL   = (64'sd1 <<< (FRAC_W - 8)) * 64'sd100000;
  localparam longint LIN_DIV   = 64'sd10005248 / 64'sd256;
  localparam int     LIN_SH    = 33;
  localparam longint LIN_RECIP = ((LIN_MUL <<< LIN_SH) + LIN_DIV - 64'sd1) / LIN_DIV;
  localparam int     LRC_W     = 43;

  // iterate clamp and output saturation
  localparam longint T_MIN   = -(64'sd1024 <<< FRAC_W);
  localparam longint T_MAX   = (64'sd1024 <<< FRAC_W) - 64'sd1;
  localparam longint OUT_MIN = -64'sd65536;
  localparam longint OUT_MAX = 64'sd270335;

  // curve coefficients in Q48
  localparam longint C0_L = 64'sd100 * (64'sd1 <<< CK);
  localparam longint C1_L = (64'sd39083 * (64'sd1 <<< 43) + 64'sd1562) / 64'sd3125;
  localparam longint C2_L = -((64'sd5775 * (64'sd1 <<< 40) + 64'sd195312) / 64'sd390625);
  localparam longint C3_L = (64'sd4183 * (64'sd1 <<< 37) + 64'sd24414062) / 64'sd48828125;
  localparam longint C4_L =
    -((64'sd4183 * (64'sd1 <<< 35) + 64'sd610351562) / 64'sd1220703125);
  localparam longint D2_L = 64'sd2 * C2_L;
  localparam longint D3_L = 64'sd3 * C3_L;
  localparam longint D4_L = 64'sd4 * C4_L;

  // configuration register indexes
  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_TOL      = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic                  load_in;
    logic                  lin_done;
    logic                  h_load;
    logic                  h_mlo;
    logic                  h_mhi;
    logic                  h_acc;
    logic                  deriv;
    logic [KIDX_W-1:0]     k;
    logic                  take_rt;
    logic                  take_dv;
    logic                  step_start;
    logic                  step_apply;
    logic                  out_load;
    logic                  conv;
    logic [ITER_W-1:0]     used;
  } rtd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic in_range;
    logic quartic;
    logic conv_hit;
  } rtd_stat_t;

  // horner coefficient sequence for value and slope, both branches
  function automatic logic signed [ACC_W-1:0] coef(input logic deriv, input logic quartic,
                                                   input logic [KIDX_W-1:0] k);
    logic signed [ACC_W-1:0] c;
    c = ACC_W'(C0_L);
    if (!deriv && quartic) begin
      case (k)
        3'd0:    c = ACC_W'(C4_L);
        3'd1:    c = ACC_W'(C3_L);
        3'd2:    c = ACC_W'(C2_L);
        3'd3:    c = ACC_W'(C1_L);
        default: c = ACC_W'(C0_L);
      endcase
    end else if (!deriv) begin
      case (k)
        3'd0:    c = ACC_W'(C2_L);
        3'd1:    c = ACC_W'(C1_L);
        default: c = ACC_W'(C0_L);
      endcase
    end else if (quartic) begin
      case (k)
        3'd0:    c = ACC_W'(D4_L);
        3'd1:    c = ACC_W'(D3_L);
        3'd2:    c = ACC_W'(D2_L);
        default: c = ACC_W'(C1_L);
      endcase
    end else begin
      case (k)
        3'd0:    c = ACC_W'(D2_L);
        default: c = ACC_W'(C1_L);
      endcase
    end
    return c;
  endfunction

  // index of the last coefficient of a horner pass
  function automatic logic [KIDX_W-1:0] horner_last(input logic deriv, input logic quartic);
    logic [KIDX_W-1:0] n;
    n = quartic ? (deriv ? 3'd3 : 3'd4) : (deriv ? 3'd1 : 3'd2);
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/rtd_div.sv
// serial restoring divider, one quotient bit per cycle, sign applied at the end
// depends on rtd_pkg
`default_nettype none

module rtd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rtd_pkg::NUM_W-1:0]         num,
  input  logic [rtd_pkg::DEN_W-1:0]         den,
  input  logic                              neg,
  output logic                              done,
  output logic signed [rtd_pkg::QUO_W-1:0]  quo
);

  localparam int CNT_W = $clog2(rtd_pkg::NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rtd_pkg::NUM_W - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [rtd_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [rtd_pkg::NUM_W-1:0]   sh_r, sh_nxt;
  logic [rtd_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic                        neg_r, neg_nxt;
  logic [rtd_pkg::DEN_W:0]     trial;
  logic [rtd_pkg::DEN_W:0]     diff;
  logic                        ge;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem_r, sh_r[rtd_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      sh_nxt   = num;
      den_nxt  = den;
      neg_nxt  = neg;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[rtd_pkg::DEN_W-1:0] : trial[rtd_pkg::DEN_W-1:0];
      sh_nxt  = {sh_r[rtd_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // truncated toward zero
  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, sh_r}) : $signed({1'b0, sh_r});

endmodule

`default_nettype wire

>>> sv/rtd_dp.sv
// datapath: linear estimate, horner multiply-accumulate, newton update, output regs
// depends on rtd_pkg and rtd_div
`default_nettype none

module rtd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rtd_pkg::TOL_W-1:0]           tolerance,
  input  logic [rtd_pkg::RES_W-1:0]           in_resistance,
  input  rtd_pkg::rtd_cmd_t                   cmd,
  output rtd_pkg::rtd_stat_t                  stat,
  output logic signed [rtd_pkg::TEMP_W-1:0]   out_temperature,
  output logic                                out_in_range,
  output logic                                out_converged,
  output logic [rtd_pkg::ITER_W-1:0]          out_iterations_used
);

  localparam int LD_W  = rtd_pkg::RES_W + 1;
  localparam int LP_W  = rtd_pkg::RES_W + rtd_pkg::LRC_W;
  localparam int LQ_W  = LP_W - rtd_pkg::LIN_SH;
  localparam int ND_W  = rtd_pkg::RT_W + 2;
  localparam int PLO_W = rtd_pkg::ACC_SPLIT + 1 + rtd_pkg::T_W;
  localparam int PHI_W = rtd_pkg::ACC_W - rtd_pkg::ACC_SPLIT + rtd_pkg::T_W;
  localparam int SUM_W = PHI_W + rtd_pkg::ACC_SPLIT;
  localparam int TS_W  = rtd_pkg::QUO_W + 1;
  localparam int DT_W  = rtd_pkg::T_W + 1;

  logic [rtd_pkg::RES_W-1:0]         r_r;
  logic signed [rtd_pkg::T_W-1:0]    t_r;
  logic signed [rtd_pkg::ACC_W-1:0]  acc_r;
  logic signed [PLO_W-1:0]           plo_r;
  logic signed [PHI_W-1:0]           phi_r;
  logic signed [rtd_pkg::RT_W-1:0]   rt_r;
  logic [rtd_pkg::DEN_W-1:0]         dv_r;

  logic                              quartic;
  logic                              in_rng;
  logic                              conv_hit;
  logic signed [LD_W-1:0]            lin_diff;
  logic [rtd_pkg::RES_W-1:0]         lin_mag;
  logic [LP_W-1:0]                   lin_prod;
  logic [LQ_W-1:0]                   lin_q;
  logic signed [rtd_pkg::T_W-1:0]    lin_t;
  logic signed [ND_W-1:0]            newt_diff;
  logic [ND_W-1:0]                   newt_abs;
  logic [rtd_pkg::NUM_W-1:0]         div_num;
  logic [rtd_pkg::DEN_W-1:0]         div_den;
  logic                              div_neg;
  logic                              div_done;
  logic signed [rtd_pkg::QUO_W-1:0]  quo;
  logic signed [SUM_W-1:0]           mac_sum;
  logic signed [rtd_pkg::RT_W-1:0]   acc_top;
  logic signed [TS_W-1:0]            tn_raw;
  logic signed [rtd_pkg::T_W-1:0]    tn;
  logic signed [DT_W-1:0]            delta;
  logic [DT_W-1:0]                   delta_mag;
  logic signed [DT_W-1:0]            o_sum;
  logic signed [DT_W-1:0]            o_sh;
  logic signed [rtd_pkg::TEMP_W-1:0] o_sat;

  // branch and range decisions
  always_comb begin
    quartic = (r_r < rtd_pkg::R_MID);
    in_rng  = (r_r >= rtd_pkg::R_LOW) && (r_r <= rtd_pkg::R_HIGH);
  end

  // status to the controller
  assign stat = {div_done, in_rng, quartic, conv_hit};

  // linear estimate by reciprocal multiply, truncated toward zero
  always_comb begin
    lin_diff = $signed({1'b0, r_r}) - $signed({1'b0, rtd_pkg::R_MID});
    lin_mag  = lin_diff[LD_W-1] ? rtd_pkg::RES_W'(-lin_diff) : rtd_pkg::RES_W'(lin_diff);
    lin_prod = LP_W'(lin_mag) * LP_W'(rtd_pkg::LIN_RECIP);
    lin_q    = lin_prod[LP_W-1:rtd_pkg::LIN_SH];
    lin_t    = lin_diff[LD_W-1] ? -$signed({1'b0, lin_q}) : $signed({1'b0, lin_q});
  end

  // divider operands for the newton step
  always_comb begin
    newt_diff = $signed(ND_W'({r_r, 8'b0})) - ND_W'(rt_r);
    newt_abs  = newt_diff[ND_W-1] ? ND_W'(-newt_diff) : ND_W'(newt_diff);
    div_num   = {newt_abs[rtd_pkg::NUM_W-rtd_pkg::FRAC_W-1:0], {rtd_pkg::FRAC_W{1'b0}}};
    div_den   = dv_r;
    div_neg   = newt_diff[ND_W-1];
  end

  rtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.step_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .done  (div_done),
    .quo   (quo)
  );

  // newton update with clamp and convergence test
  always_comb begin
    tn_raw = TS_W'(t_r) + TS_W'(quo);
    if (tn_raw < rtd_pkg::T_MIN) begin
      tn = rtd_pkg::T_W'(rtd_pkg::T_MIN);
    end else if (tn_raw > rtd_pkg::T_MAX) begin
      tn = rtd_pkg::T_W'(rtd_pkg::T_MAX);
    end else begin
      tn = tn_raw[rtd_pkg::T_W-1:0];
    end
    delta     = DT_W'(tn) - DT_W'(t_r);
    delta_mag = delta[DT_W-1] ? DT_W'(-delta) : DT_W'(delta);
    conv_hit  = (delta_mag < DT_W'(tolerance));
  end

  // horner sum of the two partial products, scaled back to q48
  always_comb begin
    mac_sum = (SUM_W'(phi_r) <<< rtd_pkg::ACC_SPLIT) + SUM_W'(plo_r);
    acc_top = acc_r[rtd_pkg::ACC_W-1 -: rtd_pkg::RT_W];
  end

  // output rounding and saturation
  always_comb begin
    o_sum = DT_W'(t_r) + DT_W'(1 << (rtd_pkg::FRAC_W - 9));
    o_sh  = o_sum >>> (rtd_pkg::FRAC_W - 8);
    if (o_sh < rtd_pkg::OUT_MIN) begin
      o_sat = rtd_pkg::TEMP_W'(rtd_pkg::OUT_MIN);
    end else if (o_sh > rtd_pkg::OUT_MAX) begin
      o_sat = rtd_pkg::TEMP_W'(rtd_pkg::OUT_MAX);
    end else begin
      o_sat = o_sh[rtd_pkg::TEMP_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_r <= in_resistance;
    end
    if (cmd.lin_done) begin
      t_r <= lin_t;
    end else if (cmd.step_apply && !conv_hit) begin
      t_r <= tn;
    end
    if (cmd.h_load) begin
      acc_r <= rtd_pkg::coef(cmd.deriv, quartic, cmd.k);
    end else if (cmd.h_acc) begin
      acc_r <= $signed(mac_sum[rtd_pkg::FRAC_W +: rtd_pkg::ACC_W]) +
               rtd_pkg::coef(cmd.deriv, quartic, cmd.k);
    end
    if (cmd.h_mlo) begin
      plo_r <= $signed({1'b0, acc_r[rtd_pkg::ACC_SPLIT-1:0]}) * t_r;
    end
    if (cmd.h_mhi) begin
      phi_r <= $signed(acc_r[rtd_pkg::ACC_W-1:rtd_pkg::ACC_SPLIT]) * t_r;
    end
    if (cmd.take_rt) begin
      rt_r <= acc_top;
    end
    if (cmd.take_dv) begin
      dv_r <= (acc_top < $signed(rtd_pkg::RT_W'(1))) ? rtd_pkg::DEN_W'(1)
                                                      : rtd_pkg::DEN_W'(acc_top);
    end
    if (cmd.out_load) begin
      out_temperature     <= o_sat;
      out_in_range        <= in_rng;
      out_converged       <= cmd.conv;
      out_iterations_used <= cmd.used;
    end
  end

endmodule

`default_nettype wire

>>> sv/rtd_ctrl.sv
// controller: sequences linear estimate, horner passes, divisions and handshakes
// depends on rtd_pkg
`default_nettype none

module rtd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rtd_pkg::ITER_W-1:0]  max_iter,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  rtd_pkg::rtd_stat_t          stat,
  output rtd_pkg::rtd_cmd_t           cmd
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_LIN      = 11'b000_0000_0010,
    ST_H_LOAD   = 11'b000_0000_0100,
    ST_H_MLO    = 11'b000_0000_1000,
    ST_H_MHI    = 11'b000_0001_0000,
    ST_H_ACC    = 11'b000_0010_0000,
    ST_TAKE     = 11'b000_0100_0000,
    ST_DIV      = 11'b000_1000_0000,
    ST_DIV_WAIT = 11'b001_0000_0000,
    ST_STEP     = 11'b010_0000_0000,
    ST_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         deriv_r, deriv_nxt;
  logic [rtd_pkg::KIDX_W-1:0]   k_r, k_nxt;
  logic [rtd_pkg::ITER_W-1:0]   cnt_r, cnt_nxt;
  logic                         conv_r, conv_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rtd_pkg::ITER_W-1:0]   cnt_inc;

  assign cnt_inc = cnt_r + 1'b1;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    deriv_nxt     = deriv_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.deriv     = deriv_r;
    cmd.k         = k_r;
    cmd.conv      = conv_r;
    cmd.used      = cnt_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          conv_nxt    = 1'b0;
          state_nxt   = ST_LIN;
        end
      end
      ST_LIN: begin
        cmd.lin_done = 1'b1;
        if (stat.in_range && (max_iter != '0)) begin
          deriv_nxt = 1'b0;
          k_nxt     = '0;
          state_nxt = ST_H_LOAD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_H_LOAD: begin
        cmd.h_load = 1'b1;
        k_nxt      = 3'd1;
        state_nxt  = ST_H_MLO;
      end
      ST_H_MLO: begin
        cmd.h_mlo = 1'b1;
        state_nxt = ST_H_MHI;
      end
      ST_H_MHI: begin
        cmd.h_mhi = 1'b1;
        state_nxt = ST_H_ACC;
      end
      ST_H_ACC: begin
        cmd.h_acc = 1'b1;
        if (k_r == rtd_pkg::horner_last(deriv_r, stat.quartic)) begin
          state_nxt = ST_TAKE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_H_MLO;
        end
      end
      ST_TAKE: begin
        if (!deriv_r) begin
          cmd.take_rt = 1'b1;
          deriv_nxt   = 1'b1;
          k_nxt       = '0;
          state_nxt   = ST_H_LOAD;
        end else begin
          cmd.take_dv = 1'b1;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step_start = 1'b1;
        state_nxt      = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step_apply = 1'b1;
        cnt_nxt        = cnt_inc;
        if (stat.conv_hit) begin
          conv_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else if (cnt_inc == max_iter) begin
          state_nxt = ST_FINISH;
        end else begin
          deriv_nxt = 1'b0;
          k_nxt     = '0;
          state_nxt = ST_H_LOAD;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      deriv_r     <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      deriv_r     <= deriv_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/rtd_resistance_to_temperature.sv
// top level: configuration registers, controller and datapath
// depends on rtd_pkg, rtd_ctrl, rtd_dp
//
// channel   direction  handshake            payload
// in_       in         in_valid / in_stall  in_resistance
// out_      out        out_valid/out_stall  out_temperature, out_in_range,
//                                           out_converged, out_iterations_used
// cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// one item at a time; in_stall is high from transfer until the result is loaded
// an item passes through transfer, the linear estimate, up to max_iter newton
// steps and the result load; a newton step runs a value and a slope horner pass
// (low product, high product, accumulate per coefficient), divider and update
// synchronous active-low reset clears control state and restores both registers
// a stalled result holds in the output register while the next item is worked on
`default_nettype none

module rtd_resistance_to_temperature (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rtd_pkg::RES_W-1:0]           in_resistance,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rtd_pkg::TEMP_W-1:0]   out_temperature,
  output logic                                out_in_range,
  output logic                                out_converged,
  output logic [rtd_pkg::ITER_W-1:0]          out_iterations_used,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [rtd_pkg::TOL_W-1:0]           cfg_wdata
);

  logic [rtd_pkg::ITER_W-1:0] max_iter_r;
  logic [rtd_pkg::TOL_W-1:0]  tol_r;
  rtd_pkg::rtd_cmd_t          cmd;
  rtd_pkg::rtd_stat_t         stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= 6'd50;
      tol_r      <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        rtd_pkg::CFG_MAX_ITER: max_iter_r <= cfg_wdata[rtd_pkg::ITER_W-1:0];
        rtd_pkg::CFG_TOL:      tol_r      <= cfg_wdata;
        default:               ;
      endcase
    end
  end

  rtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_iter  (max_iter_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rtd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .tolerance           (tol_r),
    .in_resistance       (in_resistance),
    .cmd                 (cmd),
    .stat                (stat),
    .out_temperature     (out_temperature),
    .out_in_range        (out_in_range),
    .out_converged       (out_converged),
    .out_iterations_used (out_iterations_used)
  );

endmodule

`default_nettype wire

>>> sv/rtd_chk.sv
// port-level checker for the rtd converter, bound to the top level
// depends on rtd_pkg and rtd_resistance_to_temperature_macros.svh
`default_nettype none

`include "rtd_resistance_to_temperature_macros.svh"

module rtd_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [rtd_pkg::TEMP_W-1:0]  out_temperature,
  input logic                               out_in_range,
  input logic                               out_converged,
  input logic [rtd_pkg::ITER_W-1:0]         out_iterations_used
);

  // stalled result holds
  `RTD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_temperature))

  // out-of-range result carries no newton steps
  `RTD_ASSERT_IMP(a_oor_flags, clk, rst_n, out_valid && !out_in_range, !out_converged && (out_iterations_used == '0))

  // convergence needs at least one step
  `RTD_ASSERT_IMP(a_conv_used, clk, rst_n, out_valid && out_converged, out_iterations_used != '0)

  // busy right after a transfer in
  `RTD_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind rtd_resistance_to_temperature rtd_chk u_rtd_chk (.*);

`default_nettype wire
